// File: rtl/core/expression_tokenizer_unit_macros.svh
// Assertion macros shared by the tokenizer checker.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef EXPRESSION_TOKENIZER_UNIT_MACROS_SVH
`define EXPRESSION_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ETU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ETU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// File: rtl/core/etu_pkg.sv
// Shared types, constants and character classes of the expression tokenizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package etu_pkg;

	localparam int LA_DEPTH = 8;
	localparam int PC_W     = $clog2(LA_DEPTH + 1);
	localparam int IDX_W    = $clog2(LA_DEPTH);
	localparam int CNT_W    = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [2:0] KIND_NUMBER  = 3'd0;
	localparam logic [2:0] KIND_SYMBOL  = 3'd1;
	localparam logic [2:0] KIND_WORD    = 3'd2;
	localparam logic [2:0] KIND_NEWLINE = 3'd3;
	localparam logic [2:0] KIND_COMMA   = 3'd4;

	localparam int NUM_KW = 9;
	localparam int KW_MAX = 5;
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
		'{8'h70, 8'h69, 8'h00, 8'h00, 8'h00},   // pi
		'{8'h73, 8'h69, 8'h6e, 8'h00, 8'h00},   // sin
		'{8'h63, 8'h6f, 8'h73, 8'h00, 8'h00},   // cos
		'{8'h74, 8'h61, 8'h6e, 8'h00, 8'h00},   // tan
		'{8'h6c, 8'h6f, 8'h67, 8'h00, 8'h00},   // log
		'{8'h6c, 8'h6e, 8'h00, 8'h00, 8'h00},   // ln
		'{8'h73, 8'h71, 8'h72, 8'h74, 8'h00},   // sqrt
		'{8'h61, 8'h62, 8'h73, 8'h00, 8'h00},   // abs
		'{8'h61, 8'h74, 8'h61, 8'h6e, 8'h32}    // atan2
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd4, 3'd3, 3'd5};

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_INT   = 3'd1,
		MODE_FRAC  = 3'd2,
		MODE_EXP   = 3'd3,
		MODE_IDENT = 3'd4,
		MODE_BLANK = 3'd5
	} mode_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [CNT_W-1:0] line;
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] len;
		logic [7:0]       first;
		logic             err;
		logic             last;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic emit;
		logic held_v;
		logic slot_free;
		logic end_push;
	} status_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_digit(c) || is_letter(c) || (c == 8'h5f);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d);
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		return (c == 8'h21) || (c == 8'h3d) || (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) ||
			(c == 8'h2f) || (c == 8'h5e) || (c == 8'h28) || (c == 8'h29);
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v, input logic [2:0] k);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {{(CNT_W-2){1'b0}}, k};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

// File: rtl/core/etu_ctrl.sv
// Sequencer of the tokenizer: accepts a byte, runs scan steps, closes the item.
// Depends on etu_pkg for the command and status structs.
module etu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  etu_pkg::status_t st,
	output etu_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_END  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.done) begin
					state_d = S_END;
				end else if (!(st.emit && st.held_v && !st.slot_free)) begin
					cmd.step = 1'b1;
				end
			end
			S_END: begin
				if (!st.end_push || st.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// File: rtl/core/etu_dp.sv
// Datapath of the tokenizer: pending buffer, counters, rule decode and result registers.
// Depends on etu_pkg; driven by etu_ctrl through cmd_t and reports through status_t.
module etu_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  etu_pkg::cmd_t           cmd,
	output etu_pkg::status_t        st,
	input  logic [7:0]              in_char,
	input  logic                    in_last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output etu_pkg::result_t        out_res
);

	logic [7:0]                 buf_q [etu_pkg::LA_DEPTH];
	logic [etu_pkg::PC_W-1:0]   pc_q;
	etu_pkg::mode_t             mode_q;
	logic [etu_pkg::CNT_W-1:0]  line_q, col_q, tstart_q, tlen_q;
	logic [7:0]                 ofirst_q;
	logic                       err_q, final_q, was_lat_q, any_q;
	etu_pkg::result_t           held_q, out_q;
	logic                       held_v_q, out_v_q;

	// Decode of one scan step.
	logic                       done, emit, tlen_add, open_run, newline, set_err;
	logic [2:0]                 cons_k;
	etu_pkg::mode_t             mode_d;
	etu_pkg::result_t           e_res;
	logic [7:0]                 c, c1;
	logic                       kw_wait, kw_hit;
	logic [2:0]                 kw_len;
	logic                       x_wait;
	logic [2:0]                 x_len;
	logic                       slot_free;

	assign c  = buf_q[0];
	assign c1 = buf_q[1];
	assign slot_free = !out_v_q || out_ready;

	// Keyword match; the earliest keyword in list order that completes wins.
	always_comb begin
		logic fail;
		kw_wait = 1'b0;
		kw_hit  = 1'b0;
		kw_len  = '0;
		for (int k = etu_pkg::NUM_KW - 1; k >= 0; k--) begin
			fail = 1'b0;
			for (int i = 0; i < etu_pkg::KW_MAX; i++) begin
				if (i < int'(etu_pkg::KW_LEN[k]) && i < int'(pc_q) &&
					buf_q[i] != etu_pkg::KW_TEXT[k][i]) fail = 1'b1;
			end
			if (!fail) begin
				if (int'(pc_q) < int'(etu_pkg::KW_LEN[k])) begin
					if (!final_q) kw_wait = 1'b1;
				end else if (int'(pc_q) > int'(etu_pkg::KW_LEN[k])) begin
					if (!etu_pkg::is_word(buf_q[etu_pkg::KW_LEN[k]])) begin
						kw_hit = 1'b1;
						kw_len = etu_pkg::KW_LEN[k];
					end
				end else if (final_q) begin
					kw_hit = 1'b1;
					kw_len = etu_pkg::KW_LEN[k];
				end else begin
					kw_wait = 1'b1;
				end
			end
		end
	end

	// Exponent head: e followed by a digit, or by a sign and a digit.
	always_comb begin
		x_wait = 1'b0;
		x_len  = '0;
		if (pc_q < etu_pkg::PC_W'(2)) begin
			x_wait = !final_q;
		end else if (etu_pkg::is_digit(c1)) begin
			x_len = 3'd2;
		end else if (c1 == 8'h2b || c1 == 8'h2d) begin
			if (pc_q < etu_pkg::PC_W'(3)) x_wait = !final_q;
			else if (etu_pkg::is_digit(buf_q[2])) x_len = 3'd3;
		end
	end

	always_comb begin
		logic close_run;
		logic [2:0] close_kind;
		logic now_tok;
		logic [2:0] now_kind;
		logic [2:0] now_len;
		done       = 1'b0;
		emit       = 1'b0;
		tlen_add   = 1'b0;
		open_run   = 1'b0;
		newline    = 1'b0;
		set_err    = 1'b0;
		cons_k     = '0;
		mode_d     = mode_q;
		close_run  = 1'b0;
		close_kind = etu_pkg::KIND_NUMBER;
		now_tok    = 1'b0;
		now_kind   = etu_pkg::KIND_NUMBER;
		now_len    = 3'd1;
		e_res      = '0;
		e_res.line = line_q;
		if (err_q) begin
			done = 1'b1;
		end else if (mode_q != etu_pkg::MODE_IDLE) begin
			if (pc_q == '0) begin
				if (!final_q) done = 1'b1;
				else if (mode_q == etu_pkg::MODE_BLANK) mode_d = etu_pkg::MODE_IDLE;
				else begin
					close_run  = 1'b1;
					close_kind = (mode_q == etu_pkg::MODE_IDENT) ?
						etu_pkg::KIND_WORD : etu_pkg::KIND_NUMBER;
				end
			end else begin
				case (mode_q)
					etu_pkg::MODE_INT, etu_pkg::MODE_FRAC: begin
						if (etu_pkg::is_digit(c)) begin
							tlen_add = 1'b1; cons_k = 3'd1;
						end else if (c == 8'h2e && mode_q == etu_pkg::MODE_INT) begin
							tlen_add = 1'b1; cons_k = 3'd1; mode_d = etu_pkg::MODE_FRAC;
						end else if (c == 8'h65 || c == 8'h45) begin
							if (x_wait) done = 1'b1;
							else if (x_len != '0) begin
								tlen_add = 1'b1; cons_k = x_len; mode_d = etu_pkg::MODE_EXP;
							end else close_run = 1'b1;
						end else close_run = 1'b1;
					end
					etu_pkg::MODE_EXP: begin
						if (etu_pkg::is_digit(c)) begin
							tlen_add = 1'b1; cons_k = 3'd1;
						end else close_run = 1'b1;
					end
					etu_pkg::MODE_IDENT: begin
						if (etu_pkg::is_word(c)) begin
							tlen_add = 1'b1; cons_k = 3'd1;
						end else begin
							close_run = 1'b1; close_kind = etu_pkg::KIND_WORD;
						end
					end
					default: begin
						if (etu_pkg::is_blank(c)) cons_k = 3'd1;
						else mode_d = etu_pkg::MODE_IDLE;
					end
				endcase
			end
		end else if (pc_q == '0) begin
			done = 1'b1;
		end else if (etu_pkg::is_digit(c)) begin
			open_run = 1'b1; cons_k = 3'd1; mode_d = etu_pkg::MODE_INT;
		end else if (etu_pkg::is_symbol(c)) begin
			now_tok = 1'b1; now_kind = etu_pkg::KIND_SYMBOL;
		end else if (etu_pkg::is_letter(c)) begin
			if (kw_hit) begin
				now_tok = 1'b1; now_kind = etu_pkg::KIND_WORD; now_len = kw_len;
			end else if (kw_wait) done = 1'b1;
			else if (pc_q < etu_pkg::PC_W'(2) && !final_q) done = 1'b1;
			else if (pc_q >= etu_pkg::PC_W'(2) && c1 == 8'h5f) begin
				open_run = 1'b1; cons_k = 3'd2; mode_d = etu_pkg::MODE_IDENT;
			end else begin
				now_tok = 1'b1; now_kind = etu_pkg::KIND_WORD;
			end
		end else if (c == 8'h5f) begin
			open_run = 1'b1; cons_k = 3'd1; mode_d = etu_pkg::MODE_IDENT;
		end else if (c == 8'h0a) begin
			newline     = 1'b1;
			emit        = 1'b1;
			e_res.kind  = etu_pkg::KIND_NEWLINE;
			e_res.col   = col_q;
			e_res.len   = etu_pkg::CNT_W'(1);
			e_res.first = c;
		end else if (etu_pkg::is_blank(c)) begin
			cons_k = 3'd1; mode_d = etu_pkg::MODE_BLANK;
		end else if (c == 8'h2c) begin
			now_tok = 1'b1; now_kind = etu_pkg::KIND_COMMA;
		end else begin
			// Unexpected character: report it and ignore the rest of the text.
			set_err     = 1'b1;
			emit        = 1'b1;
			mode_d      = etu_pkg::MODE_IDLE;
			e_res.kind  = etu_pkg::KIND_NUMBER;
			e_res.col   = col_q;
			e_res.first = c;
			e_res.err   = 1'b1;
			e_res.last  = 1'b1;
		end
		if (close_run) begin
			emit        = 1'b1;
			mode_d      = etu_pkg::MODE_IDLE;
			e_res.kind  = close_kind;
			e_res.col   = tstart_q;
			e_res.len   = tlen_q;
			e_res.first = ofirst_q;
		end
		if (now_tok) begin
			emit        = 1'b1;
			cons_k      = now_len;
			e_res.kind  = now_kind;
			e_res.col   = col_q;
			e_res.len   = etu_pkg::CNT_W'(now_len);
			e_res.first = c;
		end
	end

	assign st.done      = done;
	assign st.emit      = emit;
	assign st.held_v    = held_v_q;
	assign st.slot_free = slot_free;
	assign st.end_push  = held_v_q || (final_q && !any_q && !was_lat_q);

	// Pending buffer: payload only, entries are read only after being written.
	always_ff @(posedge clk) begin
		logic [etu_pkg::PC_W:0] src;
		if (cmd.load) begin
			if (!err_q && pc_q < etu_pkg::PC_W'(etu_pkg::LA_DEPTH))
				buf_q[pc_q[etu_pkg::IDX_W-1:0]] <= in_char;
		end else if (cmd.step && (cons_k != '0 || newline)) begin
			for (int i = 0; i < etu_pkg::LA_DEPTH; i++) begin
				src = (etu_pkg::PC_W+1)'(i) + (etu_pkg::PC_W+1)'(newline ? 3'd1 : cons_k);
				if (src < (etu_pkg::PC_W+1)'(etu_pkg::LA_DEPTH))
					buf_q[i] <= buf_q[src[etu_pkg::IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			mode_q    <= etu_pkg::MODE_IDLE;
			line_q    <= etu_pkg::CNT_W'(1);
			col_q     <= '0;
			tstart_q  <= '0;
			tlen_q    <= '0;
			ofirst_q  <= '0;
			err_q     <= 1'b0;
			final_q   <= 1'b0;
			was_lat_q <= 1'b0;
			any_q     <= 1'b0;
			held_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_ready) out_v_q <= 1'b0;
			if (cmd.load) begin
				final_q   <= in_last;
				was_lat_q <= err_q;
				any_q     <= 1'b0;
				if (!err_q && pc_q < etu_pkg::PC_W'(etu_pkg::LA_DEPTH)) pc_q <= pc_q + 1'b1;
			end
			if (cmd.step) begin
				mode_q <= mode_d;
				if (emit) begin
					any_q    <= 1'b1;
					held_v_q <= 1'b1;
					if (held_v_q) out_v_q <= 1'b1;
				end
				if (set_err) begin
					err_q <= 1'b1;
					pc_q  <= '0;
				end else if (newline) begin
					pc_q   <= pc_q - 1'b1;
					line_q <= etu_pkg::sat_add(line_q, 3'd1);
					col_q  <= '0;
				end else begin
					pc_q  <= pc_q - etu_pkg::PC_W'(cons_k);
					col_q <= etu_pkg::sat_add(col_q, cons_k);
				end
				if (open_run) begin
					tstart_q <= col_q;
					ofirst_q <= c;
					tlen_q   <= etu_pkg::CNT_W'(cons_k);
				end else if (tlen_add) begin
					tlen_q <= etu_pkg::sat_add(tlen_q, cons_k);
				end
			end
			if (cmd.finish) begin
				if (held_v_q) begin
					out_v_q  <= 1'b1;
					held_v_q <= 1'b0;
				end else if (st.end_push) begin
					out_v_q <= 1'b1;
				end
				if (final_q) begin
					pc_q     <= '0;
					mode_q   <= etu_pkg::MODE_IDLE;
					line_q   <= etu_pkg::CNT_W'(1);
					col_q    <= '0;
					tstart_q <= '0;
					tlen_q   <= '0;
					ofirst_q <= '0;
					err_q    <= 1'b0;
				end
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.step && emit) begin
			held_q <= e_res;
			if (held_v_q) out_q <= held_q;
		end
		if (cmd.finish) begin
			if (held_v_q) begin
				out_q      <= held_q;
				out_q.last <= held_q.last | final_q;
			end else if (st.end_push) begin
				out_q      <= '0;
				out_q.line <= line_q;
				out_q.col  <= col_q;
				out_q.last <= 1'b1;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

// File: rtl/core/expression_tokenizer_unit.sv
// Expression tokenizer: one source byte in per beat, token beats out.
// Usage: s_tdata carries one byte of text and s_tlast marks the final byte of a
// text. Each accepted beat is scanned from a pending buffer of up to eight bytes;
// the scan sequencer makes one rule decision per scan step until no further step
// can be resolved, then closes the item.
// The input is taken only while the sequencer is idle between items.
// Results pass through a one-entry holding register and an output register, so
// a token appears on the master side once the next token or the end of its item
// is known; m_tlast marks the last beat of a text, and a lex_error beat in m_tuser
// ends the text early, after which input up to s_tlast yields no beats.
// A text that ends with no token in its final item yields an end-marker beat.
// When a scan step would move a token into the output register while it is full and
// m_tready is low, the sequencer holds that step until it drains; no beat is lost.
// Reset clears the scanner to line 1, column 0, with no pending bytes.
module expression_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] line_no, [31:16] column_no,
	                               // [47:32] token_length, [55:48] first_byte
	output logic [3:0]  m_tuser,   // [2:0] token_kind, [3] lex_error
	output logic        m_tlast
);

	etu_pkg::cmd_t    cmd;
	etu_pkg::status_t st;
	etu_pkg::result_t res;

	etu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	etu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_char   (s_tdata),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.first, res.len, res.col, res.line};
	assign m_tuser = {res.err, res.kind};
	assign m_tlast = res.last;

endmodule

// File: rtl/core/etu_chk.sv
// Port-level checker for the expression tokenizer, bound to the top level.
// Depends on expression_tokenizer_unit_macros.svh.
`include "expression_tokenizer_unit_macros.svh"

module etu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	`ETU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ETU_ASSERT_NOW(a_err_last, m_tvalid && m_tuser[3], m_tlast)
	`ETU_ASSERT_NOW(a_err_len, m_tvalid && m_tuser[3], m_tdata[47:32] == 16'd0)
	`ETU_ASSERT_NOW(a_line_nz, m_tvalid, m_tdata[15:0] != 16'd0)

endmodule

bind expression_tokenizer_unit etu_chk u_etu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: dv/expression_tokenizer_unit_tb.sv
// Self-checking testbench for expression_tokenizer_unit: streams texts byte by byte and
// compares every token beat against a predictor kept in a small scoreboard class.
// Depends on etu_pkg for the result layout, the token kinds and the keyword table.
module expression_tokenizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	class token_scoreboard;
		etu_pkg::mode_t   mode;
		logic [7:0]       pend [etu_pkg::LA_DEPTH];
		int               pcnt;
		logic [15:0]      line, col, tstart, tlen;
		bit               err_seen;
		logic [7:0]       ofirst;
		etu_pkg::result_t tokens_due [$];
		etu_pkg::result_t step_tokens [$];
		int               errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			mode = etu_pkg::MODE_IDLE;
			pcnt = 0;
			line = 16'd1;
			col = '0;
			tstart = '0;
			tlen = '0;
			err_seen = 0;
			ofirst = '0;
		endfunction

		function bit digit(logic [7:0] c);
			return c inside {["0":"9"]};
		endfunction
		function bit letter(logic [7:0] c);
			return c inside {["a":"z"], ["A":"Z"]};
		endfunction
		function bit wordc(logic [7:0] c);
			return digit(c) || letter(c) || c == "_";
		endfunction
		function bit blank(logic [7:0] c);
			return c == " " || c == 8'h09 || c == 8'h0d;
		endfunction
		function bit symbol(logic [7:0] c);
			return c inside {"!", "=", "+", "-", "*", "/", "^", "(", ")"};
		endfunction
		function logic [15:0] inc(logic [15:0] v);
			return (v == 16'hffff) ? v : v + 16'd1;
		endfunction

		function void push(logic [2:0] kind, logic [15:0] c, logic [15:0] len,
				logic [7:0] first, logic e);
			etu_pkg::result_t r;
			r.kind = kind; r.line = line; r.col = c; r.len = len;
			r.first = first; r.err = e; r.last = e;
			if (step_tokens.size() < 8) step_tokens.insert(step_tokens.size(), r);
		endfunction

		function void drop(int k);
			for (int i = 0; i + k < pcnt; i++) pend[i] = pend[i + k];
			pcnt -= k;
		endfunction
		function void eat(int k);
			for (int i = 0; i < k; i++) col = inc(col);
			drop(k);
		endfunction
		function void emit_now(logic [2:0] kind, int len);
			push(kind, col, 16'(len), pend[0], 1'b0);
			eat(len);
		endfunction
		function void open_run(etu_pkg::mode_t m, int k);
			tstart = col; ofirst = pend[0]; tlen = 16'(k); eat(k); mode = m;
		endfunction
		function void grow(int k);
			for (int i = 0; i < k; i++) tlen = inc(tlen);
			eat(k);
		endfunction
		function void close_run(logic [2:0] kind);
			push(kind, tstart, tlen, ofirst, 1'b0);
			mode = etu_pkg::MODE_IDLE;
		endfunction

		// -1 undecided, 0 no exponent, else length of the exponent head
		function int exp_head(bit fin);
			if (pcnt < 2) return fin ? 0 : -1;
			if (digit(pend[1])) return 2;
			if (pend[1] == "+" || pend[1] == "-") begin
				if (pcnt < 3) return fin ? 0 : -1;
				return digit(pend[2]) ? 3 : 0;
			end
			return 0;
		endfunction

		// -1 undecided, 0 no keyword, else keyword length
		function int keyword_len(bit fin);
			bit waiting;
			bit fail, undec;
			int m;
			waiting = 0;
			for (int k = 0; k < etu_pkg::NUM_KW; k++) begin
				fail = 0; undec = 0; m = etu_pkg::KW_LEN[k];
				for (int i = 0; i < m; i++) begin
					if (i >= pcnt) begin undec = 1; break; end
					if (pend[i] != etu_pkg::KW_TEXT[k][i]) begin fail = 1; break; end
				end
				if (fail) continue;
				if (undec) begin if (!fin) waiting = 1; continue; end
				if (pcnt > m) begin
					if (!wordc(pend[m])) return m;
				end else if (fin) return m;
				else waiting = 1;
			end
			return waiting ? -1 : 0;
		endfunction

		function void scan(bit fin);
			logic [7:0] c;
			int r;
			forever begin
				if (err_seen) return;
				if (mode != etu_pkg::MODE_IDLE) begin
					if (pcnt == 0) begin
						if (!fin) return;
						if (mode == etu_pkg::MODE_BLANK) mode = etu_pkg::MODE_IDLE;
						else close_run(mode == etu_pkg::MODE_IDENT ?
							etu_pkg::KIND_WORD : etu_pkg::KIND_NUMBER);
						continue;
					end
					c = pend[0];
					case (mode)
						etu_pkg::MODE_INT, etu_pkg::MODE_FRAC: begin
							if (digit(c)) grow(1);
							else if (c == "." && mode == etu_pkg::MODE_INT) begin
								grow(1); mode = etu_pkg::MODE_FRAC;
							end else if (c == "e" || c == "E") begin
								r = exp_head(fin);
								if (r < 0) return;
								if (r > 0) begin grow(r); mode = etu_pkg::MODE_EXP; end
								else close_run(etu_pkg::KIND_NUMBER);
							end else close_run(etu_pkg::KIND_NUMBER);
						end
						etu_pkg::MODE_EXP:
							if (digit(c)) grow(1); else close_run(etu_pkg::KIND_NUMBER);
						etu_pkg::MODE_IDENT:
							if (wordc(c)) grow(1); else close_run(etu_pkg::KIND_WORD);
						default: if (blank(c)) eat(1); else mode = etu_pkg::MODE_IDLE;
					endcase
					continue;
				end
				if (pcnt == 0) return;
				c = pend[0];
				if (digit(c)) open_run(etu_pkg::MODE_INT, 1);
				else if (symbol(c)) emit_now(etu_pkg::KIND_SYMBOL, 1);
				else if (letter(c)) begin
					r = keyword_len(fin);
					if (r < 0) return;
					if (r > 0) emit_now(etu_pkg::KIND_WORD, r);
					else if (pcnt < 2 && !fin) return;
					else if (pcnt >= 2 && pend[1] == "_") open_run(etu_pkg::MODE_IDENT, 2);
					else emit_now(etu_pkg::KIND_WORD, 1);
				end else if (c == "_") open_run(etu_pkg::MODE_IDENT, 1);
				else if (c == 8'h0a) begin
					push(etu_pkg::KIND_NEWLINE, col, 16'd1, c, 1'b0);
					drop(1);
					line = inc(line);
					col = '0;
				end else if (blank(c)) begin mode = etu_pkg::MODE_BLANK; eat(1); end
				else if (c == ",") emit_now(etu_pkg::KIND_COMMA, 1);
				else begin
					push(etu_pkg::KIND_NUMBER, col, 16'd0, c, 1'b1);
					err_seen = 1; pcnt = 0; mode = etu_pkg::MODE_IDLE;
					return;
				end
			end
		endfunction

		// Called for every accepted input beat.
		function void note_byte(logic [7:0] c, bit fin);
			bit was_err;
			etu_pkg::result_t r;
			was_err = err_seen;
			step_tokens.delete();
			if (!was_err) begin
				if (pcnt < etu_pkg::LA_DEPTH) begin pend[pcnt] = c; pcnt++; end
				scan(fin);
			end
			if (fin) begin
				if (step_tokens.size() > 0) step_tokens[$].last = 1;
				else if (!was_err) begin
					r = '0; r.line = line; r.col = col; r.last = 1;
					step_tokens.insert(step_tokens.size(), r);
				end
				clear();
			end
			foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
		endfunction

		function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Called for every accepted output beat.
		function void check_token(logic [55:0] d, logic [3:0] u, logic l);
			etu_pkg::result_t e;
			if (tokens_due.size() == 0) begin
				$error("unexpected token beat: tdata %h tuser %h", d, u);
				errors++;
				return;
			end
			e = tokens_due.pop_front();
			cmp("token_kind", e.kind, u[2:0]);
			cmp("line_no", e.line, d[15:0]);
			cmp("column_no", e.col, d[31:16]);
			cmp("token_length", e.len, d[47:32]);
			cmp("first_byte", e.first, d[55:48]);
			cmp("lex_error", e.err, u[3]);
			cmp("stream_end", e.last, l);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	token_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_request;
	int  hold_left;
	int  bytes_sent;

	expression_tokenizer_unit dut (.*);

	initial clk = 0;
	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_token(m_tdata, m_tuser, m_tlast);
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_byte(logic [7:0] c, bit fin);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(c, fin);
		bytes_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	// Random piece of the language; mostly well-formed, some odd bytes.
	function automatic string piece();
		string p;
		string syms;
		syms = "!=+-*/^()";
		case ($urandom_range(15))
			0, 1: p = $sformatf("%0d", $urandom_range(999));
			2: p = $sformatf("%0d.%0d", $urandom_range(99), $urandom_range(99));
			3: p = $sformatf("%0de%s%0d", $urandom_range(9),
				($urandom_range(1) ? "-" : "+"), $urandom_range(20));
			4: p = $urandom_range(1) ? "2e" : "3.E+";
			5: begin
				p = " ";
				p[0] = syms[$urandom_range(8)];
			end
			6: case ($urandom_range(8))
				0: p = "pi"; 1: p = "sin"; 2: p = "cos"; 3: p = "tan"; 4: p = "log";
				5: p = "ln"; 6: p = "sqrt"; 7: p = "abs"; default: p = "atan2";
			endcase
			7: p = $urandom_range(1) ? "sint" : "atan";
			8: p = $urandom_range(1) ? "_a9" : "x_y1";
			9: begin
				p = " ";
				p[0] = 8'("a" + $urandom_range(25));
			end
			10: p = $urandom_range(1) ? " \t" : "\015 ";
			11: p = "\n";
			12: p = ",";
			13: p = "(";
			14: begin
				p = " ";
				p[0] = 8'($urandom_range(255));
			end
			default: p = $urandom_range(1) ? "#" : " ";
		endcase
		return p;
	endfunction

	// The sender goes quiet until every expected beat has been seen.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.tokens_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		string t;
		sb = new();
		send_idle_pct = 28;
		recv_idle_pct = 76;
		hold_request = 0;
		hold_left = 0;
		bytes_sent = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: numbers with and without exponents, every symbol, keywords,
		// identifiers, leading newline, blanks, a bad character and ignored tail.
		send_text("\n1.5e+3 2e 7E-");
		send_text("!=+-*/^(),sin atan2x");
		send_text("_ a_b9 pi");
		send_text("x#yy\n");
		send_text(" ");
		send_byte(8'hff, 1);

		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			if (ph == 1) begin
				send_idle_pct = 76;
				recv_idle_pct = 28;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_request = 300;
			end
			while (bytes_sent < 100 * (ph + 1) + 40) begin
				t = "";
				repeat ($urandom_range(1, 8)) t = {t, piece()};
				send_text(t);
			end
		end
		wait_drained();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.tokens_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
